>>> rtl/core/mpk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpk_pkg: shared definitions for the k-transaction profit tracker
// Widths, table depth, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package mpk_pkg;

	// Table depth: entries 0..MAX_K
	localparam int MAX_K      = 16;
	localparam int PRICE_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_K + 1);

	// Fixed field widths
	localparam int PRICE_W    = 16;
	localparam int K_LIMIT_W  = 5;
	localparam int PROFIT_W   = 32;
	localparam int RESULT_W   = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Holding value that marks "no position possible yet"
	localparam logic signed [PROFIT_W-1:0] NEG_MARK   = {1'b1, {(PROFIT_W-1){1'b0}}};
	localparam logic signed [PROFIT_W-1:0] PROFIT_TOP = {1'b0, {(PROFIT_W-1){1'b1}}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_K_LIMIT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_UNLIMITED = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FINISH
	} mpk_state_t;

endpackage

>>> rtl/core/mpk_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpk_if: stream channels of the k-transaction profit tracker
// Price beats in, profit beats out, and a register write channel.
// ----------------------------------------------------------------------------
interface mpk_in_if;
	logic                         valid;
	logic                         ready;
	logic [mpk_pkg::PRICE_W-1:0]  price;
	logic                         first;

	modport source (output valid, output price, output first, input ready);
	modport sink   (input valid, input price, input first, output ready);
endinterface

interface mpk_out_if;
	logic                         valid;
	logic                         ready;
	logic [mpk_pkg::RESULT_W-1:0] profit;
	logic                         saturated;

	modport source (output valid, output profit, output saturated, input ready);
	modport sink   (input valid, input profit, input saturated, output ready);
endinterface

interface mpk_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mpk_pkg::CFG_IDX_W-1:0]  index;
	logic [mpk_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/max_profit_k_transactions.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_profit_k_transactions: best trading profit over a price stream
// Tracks, for every transaction count, the best flat and holding profit and
// reports the best closed-position profit after each price beat.
// ----------------------------------------------------------------------------
// Each price beat yields one result beat: the best profit with every position
// closed, using at most k_limit buy-sell pairs (k_limit above MAX_K acts as
// MAX_K, zero gives zero), or, with unlimited_mode set, the profit of the
// any-number-of-trades recurrence. Both recurrences run on every beat, so the
// mode may be switched mid-series. A beat with first set clears all state
// before its price is used. Profit values clamp at 2^31-1 and set the
// saturated flag, which stays up until reset or the next first beat.
// An item occupies the block from acceptance until its result is loaded: the
// beat is taken, the unlimited recurrence steps, then the single shared
// sell/buy unit visits table entries 1..k in order (k the clamped k_limit),
// each using the flat value just written for its lower neighbor; then the
// result is loaded, which waits while the previous result still sits unread.
// The input is not ready from the cycle after acceptance until the result is
// loaded, so no new beat is taken before the last one is through. The result
// sits in an output register, so the next price is taken while a result still
// waits. Registers must be written by the user only while the block is idle;
// the block does not enforce this. cfg.ready is always high.
// ----------------------------------------------------------------------------
module max_profit_k_transactions (
	input  logic       clk,
	input  logic       arst_n,
	mpk_in_if.sink     item,
	mpk_out_if.source  result,
	mpk_cfg_if.sink    cfg
);

	localparam int PW = mpk_pkg::PROFIT_W;
	localparam int SW = mpk_pkg::PROFIT_W + 2;

	// Configuration
	logic [mpk_pkg::K_LIMIT_W-1:0] k_limit_q;
	logic                          unlimited_q;

	// Sequencer
	mpk_pkg::mpk_state_t state_q, state_d;
	logic [mpk_pkg::IDX_W-1:0] j_q;
	logic [mpk_pkg::IDX_W-1:0] k_q;
	logic [mpk_pkg::IDX_W-1:0] k_eff;
	logic [mpk_pkg::PRICE_BITS-1:0] price_q;

	// Profit table and unlimited recurrence
	logic signed [PW-1:0] cash_q [mpk_pkg::MAX_K+1];
	logic signed [PW-1:0] hold_q [mpk_pkg::MAX_K+1];
	logic signed [PW-1:0] free_cash_q;
	logic signed [PW-1:0] free_hold_q;
	logic signed [PW-1:0] prev_cash_q;
	logic                 sat_q;

	// Output register
	logic                            out_valid_q;
	logic [mpk_pkg::RESULT_W-1:0]    profit_q;
	logic                            out_sat_q;

	// Control decode
	logic accept;
	logic step_en;
	logic load_out;

	// Shared sell/buy unit
	logic signed [PW-1:0] cash_u, hold_u, prev_u;
	logic signed [SW-1:0] sale_sum;
	logic signed [SW-1:0] buy_sum;
	logic signed [PW-1:0] sale_v, buy_v;
	logic signed [PW-1:0] new_cash, new_hold;
	logic                 hold_live;
	logic                 sat_hit;

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_limit_q   <= mpk_pkg::K_LIMIT_W'(2);
			unlimited_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mpk_pkg::REG_K_LIMIT:   k_limit_q   <= cfg.data;
				mpk_pkg::REG_UNLIMITED: unlimited_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Clamp the transaction count to the table depth
	always_comb begin
		if (int'(k_limit_q) > mpk_pkg::MAX_K) begin
			k_eff = mpk_pkg::IDX_W'(mpk_pkg::MAX_K);
		end else begin
			k_eff = mpk_pkg::IDX_W'(k_limit_q);
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: take a beat, run the unlimited step (j = 0), sweep
	// table entries 1..k, then load the result register.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpk_pkg::ST_IDLE: begin
				if (item.valid) begin
					state_d = mpk_pkg::ST_STEP;
				end
			end
			mpk_pkg::ST_STEP: begin
				if (j_q == k_q) begin
					state_d = mpk_pkg::ST_FINISH;
				end
			end
			mpk_pkg::ST_FINISH: begin
				if (!out_valid_q || result.ready) begin
					state_d = mpk_pkg::ST_IDLE;
				end
			end
			default: state_d = mpk_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		step_en    = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			mpk_pkg::ST_IDLE:   item.ready = 1'b1;
			mpk_pkg::ST_STEP:   step_en    = 1'b1;
			mpk_pkg::ST_FINISH: load_out   = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign accept = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpk_pkg::ST_IDLE;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				j_q <= '0;
				k_q <= k_eff;
			end else if (step_en) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// Hold the price for the whole sweep, reduced to PRICE_BITS
	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= mpk_pkg::PRICE_BITS'(item.price);
		end
	end

	// ------------------------------------------------------------------
	// Shared unit. Step 0 feeds the unlimited pair, whose buy uses the
	// flat value from before this price; table steps buy from the entry
	// below, just updated and held in prev_cash_q.
	// ------------------------------------------------------------------
	always_comb begin
		if (j_q == '0) begin
			cash_u = free_cash_q;
			hold_u = free_hold_q;
			prev_u = free_cash_q;
		end else begin
			cash_u = cash_q[j_q];
			hold_u = hold_q[j_q];
			prev_u = prev_cash_q;
		end
	end

	always_comb begin
		hold_live = (hold_u != mpk_pkg::NEG_MARK);

		// Sell: hold + price, clamped at the top of the profit range
		sale_sum = {{2{hold_u[PW-1]}}, hold_u} + SW'(price_q);
		sat_hit  = hold_live && (sale_sum > SW'(mpk_pkg::PROFIT_TOP));
		sale_v   = sat_hit ? mpk_pkg::PROFIT_TOP : sale_sum[PW-1:0];
		new_cash = (hold_live && (sale_v > cash_u)) ? sale_v : cash_u;

		// Buy: flat value below minus price; never reaches the marker
		buy_sum  = {{2{prev_u[PW-1]}}, prev_u} - SW'(price_q);
		buy_v    = buy_sum[PW-1:0];
		new_hold = (!hold_live || (buy_v > hold_u)) ? buy_v : hold_u;
	end

	// ------------------------------------------------------------------
	// State update: first beat clears everything, steps write back.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= mpk_pkg::MAX_K; i++) begin
				cash_q[i] <= '0;
				hold_q[i] <= mpk_pkg::NEG_MARK;
			end
			free_cash_q <= '0;
			free_hold_q <= mpk_pkg::NEG_MARK;
			prev_cash_q <= '0;
			sat_q       <= 1'b0;
		end else if (accept) begin
			// Entry 0 stays flat at zero, so the first table buy starts from 0
			prev_cash_q <= '0;
			if (item.first) begin
				for (int i = 0; i <= mpk_pkg::MAX_K; i++) begin
					cash_q[i] <= '0;
					hold_q[i] <= mpk_pkg::NEG_MARK;
				end
				free_cash_q <= '0;
				free_hold_q <= mpk_pkg::NEG_MARK;
				sat_q       <= 1'b0;
			end
		end else if (step_en) begin
			if (sat_hit) begin
				sat_q <= 1'b1;
			end
			if (j_q == '0) begin
				free_cash_q <= new_cash;
				free_hold_q <= new_hold;
			end else begin
				cash_q[j_q] <= new_cash;
				hold_q[j_q] <= new_hold;
				prev_cash_q <= new_cash;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register. After the sweep prev_cash_q holds entry k (zero
	// when k is zero); both candidates are never negative.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			profit_q  <= unlimited_q ? free_cash_q[mpk_pkg::RESULT_W-1:0]
			                         : prev_cash_q[mpk_pkg::RESULT_W-1:0];
			out_sat_q <= sat_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.profit    = profit_q;
	assign result.saturated = out_sat_q;

endmodule

>>> verif/max_profit_k_transactions_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_profit_k_transactions_tb: self-checking bench for the profit tracker
// Drives price beats and register writes, predicts every result beat with a
// scoreboard that runs both the k-limited table and the unlimited recurrence,
// and compares each result beat field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module max_profit_k_transactions_tb;
	import mpk_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int MAX_REPORTS = 20;

	typedef struct packed {
		logic [RESULT_W-1:0] profit;
		logic                saturated;
	} profit_beat_t;

	// ------------------------------------------------------------------
	// Scoreboard: tracks the profit tables and holds the result beats due
	// ------------------------------------------------------------------
	class profit_scoreboard;
		int                   flat_tbl [0:MAX_K];
		int                   long_tbl [0:MAX_K];
		int                   free_flat;
		int                   free_long;
		bit                   clamp_seen;
		logic [K_LIMIT_W-1:0] k_reg;
		bit                   unlimited_reg;
		profit_beat_t         due[$];
		int                   faults;

		function new();
			k_reg         = K_LIMIT_W'(2);
			unlimited_reg = 1'b0;
			faults        = 0;
			wipe_series();
		endfunction

		function void wipe_series();
			for (int j = 0; j <= MAX_K; j++) begin
				flat_tbl[j] = 0;
				long_tbl[j] = int'(NEG_MARK);
			end
			free_flat  = 0;
			free_long  = int'(NEG_MARK);
			clamp_seen = 1'b0;
		endfunction

		// Best flat value: stay flat or sell the held share, clamped at the top
		function int sell_close(int flat, int held, logic [PRICE_W-1:0] p);
			longint best;
			longint v;
			best = flat;
			if (held != int'(NEG_MARK)) begin
				v = longint'(held) + longint'(p);
				if (v > longint'(PROFIT_TOP)) begin
					v          = longint'(PROFIT_TOP);
					clamp_seen = 1'b1;
				end
				if (v > best)
					best = v;
			end
			return int'(best);
		endfunction

		// Best holding value: keep the share or buy from the lower flat value
		function int buy_open(int held, int flat_below, logic [PRICE_W-1:0] p);
			longint v;
			v = longint'(flat_below) - longint'(p);
			if (held == int'(NEG_MARK) || v > longint'(held))
				return int'(v);
			return held;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_K_LIMIT)
				k_reg = val[K_LIMIT_W-1:0];
			else if (idx == REG_UNLIMITED)
				unlimited_reg = val[0];
		endfunction

		// Advance both recurrences by one accepted price beat
		function void note_price(logic [PRICE_W-1:0] p, logic first);
			int           k;
			int           prev_flat;
			longint       best;
			profit_beat_t beat;
			k = (k_reg > MAX_K) ? MAX_K : int'(k_reg);
			if (first)
				wipe_series();
			flat_tbl[0] = 0;
			long_tbl[0] = int'(NEG_MARK);
			// Entry j uses the flat value of j-1 already updated for this price
			for (int j = 1; j <= k; j++) begin
				flat_tbl[j] = sell_close(flat_tbl[j], long_tbl[j], p);
				long_tbl[j] = buy_open(long_tbl[j], flat_tbl[j-1], p);
			end
			prev_flat = free_flat;
			free_flat = sell_close(free_flat, free_long, p);
			free_long = buy_open(free_long, prev_flat, p);
			best = unlimited_reg ? longint'(free_flat) : longint'(flat_tbl[k]);
			if (best < 0)
				best = 0;
			beat.profit    = best[RESULT_W-1:0];
			beat.saturated = clamp_seen;
			due.push_back(beat);
		endfunction

		function void check_result(logic [RESULT_W-1:0] profit, logic saturated);
			profit_beat_t want;
			if (due.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("%0t: result beat with nothing due: profit %0d saturated %0b",
						$time, profit, saturated);
				return;
			end
			want = due.pop_front();
			if (profit !== want.profit) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("%0t: profit mismatch: expected %0d, actual %0d",
						$time, want.profit, profit);
			end
			if (saturated !== want.saturated) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("%0t: saturated mismatch: expected %0b, actual %0b",
						$time, want.saturated, saturated);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mpk_in_if  item_ch ();
	mpk_out_if res_ch ();
	mpk_cfg_if cfg_ch ();

	max_profit_k_transactions u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	profit_scoreboard sb = new();

	int send_idle_pct;
	int stall_pct;
	int hold_req;
	int hold_left;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sample every handshake at the rising edge; results first, since a result
	// beat always belongs to a price beat taken at an earlier edge
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.profit, res_ch.saturated);
		if (item_ch.valid && item_ch.ready)
			sb.note_price(item_ch.price, item_ch.first);
		if (cfg_ch.valid && cfg_ch.ready)
			sb.set_reg(cfg_ch.index, cfg_ch.data);
	end

	// Result sink: random stalls, plus a long hold-off on request, counted here
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one price beat, idling first at the current sender rate; return at
	// the falling edge after the handshake with valid still high
	task automatic send_item(input logic [PRICE_W-1:0] p, input bit first);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.price <= p;
		item_ch.first <= first;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, wait for every due result, then let the block go quiet
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (MAX_K + 6) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Random price series: mostly opened by a first beat, some carried on
	// from the previous series, with a stray first beat now and then
	task automatic random_items(input int count);
		int                 sent;
		int                 run_len;
		int                 pos;
		bit                 first;
		logic [PRICE_W-1:0] p;
		sent = 0;
		p    = PRICE_W'($urandom);
		while (sent < count) begin
			run_len = $urandom_range(40, 1);
			for (pos = 0; pos < run_len && sent < count; pos++) begin
				case ($urandom_range(3))
					0: p = PRICE_W'($urandom);
					1: p = PRICE_W'(p + $urandom_range(200) - 100);
					2: p = $urandom_range(1) ? '1 : '0;
					default: p = PRICE_W'($urandom_range(1000));
				endcase
				if (pos == 0)
					first = ($urandom_range(9) != 0);
				else
					first = ($urandom_range(49) == 0);
				send_item(p, first);
				sent++;
			end
		end
	endtask

	initial begin
		int k_set [6];
		int unl_set [6];
		int send_set [4];
		int stall_set [4];

		k_set     = '{2, 16, 0, 31, 17, 7};
		unl_set   = '{0, 0, 1, 0, 0, 1};
		send_set  = '{0, 73, 0, 17};
		stall_set = '{0, 0, 73, 17};

		// Known values on every input from time zero
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.price = '0;
		item_ch.first = 1'b0;
		res_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = REG_K_LIMIT;
		cfg_ch.data   = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 0;
		hold_left     = 0;
		cycle_count   = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset settings (k = 2, limited) on a short series
		send_item(16'd100, 1'b1);
		send_item(16'd50, 1'b0);
		send_item(16'd300, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		// Zero k mid-series: profit drops to zero
		drain();
		cfg_write(REG_K_LIMIT, CFG_DATA_W'(0));
		send_item(16'd10, 1'b0);
		send_item(16'd40000, 1'b0);
		// k above the table size acts as the full table; higher entries
		// still hold values from before the k change
		drain();
		cfg_write(REG_K_LIMIT, CFG_DATA_W'(31));
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'd1, 1'b0);
		// Switch to unlimited mid-series, then restart a series on a top price
		drain();
		cfg_write(REG_UNLIMITED, CFG_DATA_W'(1));
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'hFFFF, 1'b1);
		send_item(16'd0, 1'b0);
		send_item(16'd12345, 1'b0);
		// Full table, limited, with a first beat in the middle
		drain();
		cfg_write(REG_K_LIMIT, CFG_DATA_W'(MAX_K));
		cfg_write(REG_UNLIMITED, CFG_DATA_W'(0));
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'd1, 1'b1);
		send_item(16'hFFFE, 1'b0);
		// Single transaction, alternating bit patterns
		drain();
		cfg_write(REG_K_LIMIT, CFG_DATA_W'(1));
		send_item(16'h5555, 1'b0);
		send_item(16'hAAAA, 1'b0);

		// Unlimited recurrence on a fresh series of wide swings, then clear
		// it with a first beat
		drain();
		cfg_write(REG_UNLIMITED, CFG_DATA_W'(1));
		send_item(16'd0, 1'b1);
		send_item(16'hFFFF, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'd7, 1'b1);
		send_item(16'd9, 1'b0);

		// Random phases: each with its own settings and idling pattern
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			cfg_write(REG_K_LIMIT, CFG_DATA_W'(k_set[ph]));
			cfg_write(REG_UNLIMITED, CFG_DATA_W'(unl_set[ph]));
			send_idle_pct = send_set[ph % 4];
			stall_pct     = stall_set[ph % 4];
			if (ph == 0) begin
				// Hold the sink off for a long stretch while prices keep coming,
				// so the result register fills and the input stalls
				@(posedge clk);
				hold_req = 300;
				@(negedge clk);
			end
			random_items(100);
		end

		drain();
		if (sb.faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
